/* rtl/iocm_pkg.sv */
`default_nettype none
package iocm_pkg;

    localparam int BUS_W = 16;
    localparam int CNT_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int STROBE_W = 10;
    localparam int RESET_W = 24;
    localparam int ALE_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALE_TICKS = 2'd2;

    localparam logic [STROBE_W-1:0] STROBE_RST = 10'd50;
    localparam logic [RESET_W-1:0] RESET_RST = 24'd20000;
    localparam logic [ALE_W-1:0] ALE_RST = 4'd1;

    typedef struct packed {
        logic [STROBE_W-1:0] strobe_min_ticks;
        logic [RESET_W-1:0] reset_ticks;
        logic [ALE_W-1:0] ale_ticks;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic kind;
        logic [BUS_W-1:0] address;
        logic [BUS_W-1:0] data;
        logic iochrdy;
        logic [BUS_W-1:0] bus_in;
    } t_req;

    typedef struct packed {
        logic card_reset;
        logic ale;
        logic ior_n;
        logic iow_n;
        logic dir;
        logic bus_drive;
        logic [BUS_W-1:0] bus_out;
        logic busy;
        logic done;
        logic [BUS_W-1:0] read_data;
    } t_pins;

endpackage
`default_nettype wire

/* rtl/isa_io_cycle_master_unit.sv */
`default_nettype none
// Pin-level ISA I/O cycle master for a multiplexed 16-bit address/data bus.
// Each input item is one tick of sampled pins plus an optional request; each
// accepted item yields exactly one result item holding the pin levels for that
// tick. An item is taken every clock cycle while the input is not stalled, and
// its result is registered; the input stalls only while the output register
// is full and stalled. After reset card reset is held for reset_ticks items,
// then a write of 0 to address 0 runs. A cycle lasts ale_ticks items of
// address phase, strobe_min_ticks items of strobe, then as many items as it
// takes to see iochrdy high, with no timeout. Requests are taken only when
// busy_res is 0. Register writes are taken at once (cfg ready is always high).
module isa_io_cycle_master_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_req_valid,
    input  wire logic                             i_req_type,
    input  wire logic [iocm_pkg::BUS_W-1:0]       i_req_address,
    input  wire logic [iocm_pkg::BUS_W-1:0]       i_req_data,
    input  wire logic                             i_iochrdy,
    input  wire logic [iocm_pkg::BUS_W-1:0]       i_bus_in,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_card_reset,
    output logic                                  o_ale,
    output logic                                  o_ior_n,
    output logic                                  o_iow_n,
    output logic                                  o_dir,
    output logic                                  o_bus_drive,
    output logic [iocm_pkg::BUS_W-1:0]            o_bus_out,
    output logic                                  o_busy_res,
    output logic                                  o_done_res,
    output logic [iocm_pkg::BUS_W-1:0]            o_read_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [iocm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [iocm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import iocm_pkg::*;

    t_cfg  cfg;
    t_req  req;
    t_pins seq_pins;
    t_pins out_pins;
    logic  accept;

    assign o_cfg_ready = 1'b1;

    assign req.valid = i_req_valid;
    assign req.kind = i_req_type;
    assign req.address = i_req_address;
    assign req.data = i_req_data;
    assign req.iochrdy = i_iochrdy;
    assign req.bus_in = i_bus_in;

    iocm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iocm_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .i_cfg    (cfg),
        .o_pins   (seq_pins)
    );

    iocm_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .i_pins      (seq_pins),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pins      (out_pins)
    );

    assign o_card_reset = out_pins.card_reset;
    assign o_ale = out_pins.ale;
    assign o_ior_n = out_pins.ior_n;
    assign o_iow_n = out_pins.iow_n;
    assign o_dir = out_pins.dir;
    assign o_bus_drive = out_pins.bus_drive;
    assign o_bus_out = out_pins.bus_out;
    assign o_busy_res = out_pins.busy;
    assign o_done_res = out_pins.done;
    assign o_read_data = out_pins.read_data;

    a_strobes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ior_n || o_iow_n))
        else $error("read and write strobes low together");

    a_done_strobes_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_ior_n && o_iow_n && o_busy_res))
        else $error("cycle completion with strobe still asserted");

    a_idle_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> (!o_bus_drive && !o_dir && o_bus_out == '0))
        else $error("bus driven while idle");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_card_reset) |-> (!o_ale && !o_bus_drive && !o_done_res))
        else $error("bus activity during card reset");

endmodule
`default_nettype wire

/* rtl/iocm_cfg.sv */
`default_nettype none
module iocm_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [iocm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [iocm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output iocm_pkg::t_cfg                        o_cfg
);
    import iocm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe_min_ticks <= STROBE_RST;
            r_cfg.reset_ticks <= RESET_RST;
            r_cfg.ale_ticks <= ALE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STROBE_MIN:  r_cfg.strobe_min_ticks <= i_cfg_data[STROBE_W-1:0];
                CFG_RESET_TICKS: r_cfg.reset_ticks <= i_cfg_data[RESET_W-1:0];
                CFG_ALE_TICKS:   r_cfg.ale_ticks <= i_cfg_data[ALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* rtl/iocm_seq.sv */
`default_nettype none
module iocm_seq (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire iocm_pkg::t_req i_req,
    input  wire iocm_pkg::t_cfg i_cfg,
    output iocm_pkg::t_pins o_pins
);
    import iocm_pkg::*;

    localparam logic [3:0] PH_RESET  = 4'd0;
    localparam logic [3:0] PH_IDLE   = 4'd1;
    localparam logic [3:0] PH_ADDR   = 4'd2;
    localparam logic [3:0] PH_STROBE = 4'd3;
    localparam logic [3:0] PH_WAIT   = 4'd4;

    logic [3:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_tick, n_tick;
    logic [BUS_W-1:0] r_addr, n_addr;
    logic [BUS_W-1:0] r_data, n_data;
    logic             r_kind, n_kind;
    logic [BUS_W-1:0] r_cap, n_cap;

    logic [CNT_W-1:0] span_len;
    logic [CNT_W-1:0] span_lim;
    logic             span_end;
    t_pins            pins;

    // one span compare shared by the timed phases; a zero length acts like one
    always_comb begin
        case (r_phase)
            PH_RESET: span_len = CNT_W'(i_cfg.reset_ticks);
            PH_ADDR:  span_len = CNT_W'(i_cfg.ale_ticks);
            default:  span_len = CNT_W'(i_cfg.strobe_min_ticks);
        endcase
        span_lim = (span_len == '0) ? CNT_W'(1) : span_len;
        span_end = ({1'b0, r_tick} + (CNT_W+1)'(1)) >= {1'b0, span_lim};
    end

    always_comb begin
        n_phase = r_phase;
        n_tick = r_tick;
        n_addr = r_addr;
        n_data = r_data;
        n_kind = r_kind;
        n_cap = r_cap;
        pins = '0;
        pins.ior_n = 1'b1;
        pins.iow_n = 1'b1;
        pins.busy = 1'b1;

        case (r_phase)
            PH_RESET: begin
                pins.card_reset = 1'b1;
                if (span_end) begin
                    n_addr = '0;
                    n_data = '0;
                    n_kind = 1'b0;
                    n_tick = '0;
                    n_phase = PH_ADDR;
                end else begin
                    n_tick = r_tick + CNT_W'(1);
                end
            end
            PH_ADDR: begin
                pins.ale = 1'b1;
                pins.dir = 1'b1;
                pins.bus_drive = 1'b1;
                pins.bus_out = r_addr;
                if (span_end) begin
                    n_tick = '0;
                    n_phase = PH_STROBE;
                end else begin
                    n_tick = r_tick + CNT_W'(1);
                end
            end
            PH_STROBE: begin
                if (r_kind) begin
                    pins.ior_n = 1'b0;
                end else begin
                    pins.iow_n = 1'b0;
                    pins.dir = 1'b1;
                    pins.bus_drive = 1'b1;
                    pins.bus_out = r_data;
                end
                if (span_end) begin
                    n_tick = '0;
                    n_phase = PH_WAIT;
                end else begin
                    n_tick = r_tick + CNT_W'(1);
                end
            end
            PH_WAIT: begin
                if (!r_kind) begin
                    pins.dir = 1'b1;
                    pins.bus_drive = 1'b1;
                    pins.bus_out = r_data;
                end
                if (i_req.iochrdy) begin
                    // strobe already released on the ready tick
                    if (r_kind) begin
                        n_cap = i_req.bus_in;
                    end
                    pins.done = 1'b1;
                    n_phase = PH_IDLE;
                    n_tick = '0;
                end else if (r_kind) begin
                    pins.ior_n = 1'b0;
                end else begin
                    pins.iow_n = 1'b0;
                end
            end
            default: begin
                pins.busy = 1'b0;
                if (i_req.valid) begin
                    n_addr = i_req.address;
                    n_data = i_req.data;
                    n_kind = i_req.kind;
                    n_phase = PH_ADDR;
                end else begin
                    n_phase = PH_IDLE;
                end
                n_tick = '0;
            end
        endcase
        pins.read_data = n_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RESET;
            r_tick <= '0;
            r_addr <= '0;
            r_data <= '0;
            r_kind <= 1'b0;
            r_cap <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick <= n_tick;
            r_addr <= n_addr;
            r_data <= n_data;
            r_kind <= n_kind;
            r_cap <= n_cap;
        end
    end

    assign o_pins = pins;

endmodule
`default_nettype wire

/* rtl/iocm_out.sv */
`default_nettype none
module iocm_out (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_accept,
    input  wire iocm_pkg::t_pins i_pins,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output iocm_pkg::t_pins o_pins
);
    import iocm_pkg::*;

    logic  r_valid;
    t_pins r_pins;

    // a new item enters whenever the result register is empty or being taken
    assign o_in_stall = r_valid && i_out_stall;
    assign o_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_accept) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_pins <= i_pins;
        end
    end

    assign o_out_valid = r_valid;
    assign o_pins = r_pins;

endmodule
`default_nettype wire
